### hw/rtl/ipu_pkg.sv
// shared widths, register indexes and pixel type of the integer pixel upscaler
package ipu_pkg;

   // fixed field widths
   localparam int COLOR_W    = 8;
   localparam int PIXEL_W    = 3 * COLOR_W;
   localparam int PAD_W      = 2;
   localparam int WIDTH_REG_W  = 13;
   localparam int FACTOR_REG_W = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = WIDTH_REG_W;

   // defaults for the top level parameters
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_FACTOR = 64;

   // register indexes on the csr channel
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INPUT_WIDTH  = 1'b0,
      CSR_SCALE_FACTOR = 1'b1
   } csr_index_type;

   // input item kinds
   typedef enum logic {
      ACT_PIXEL  = 1'b0,
      ACT_REPLAY = 1'b1
   } action_type;

   // packed pixel, blue in the low byte
   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

endpackage

### hw/rtl/ipu_channels.sv
// valid/ready channel interfaces of the integer pixel upscaler

// input pixel or replay request
interface ipu_req_if import ipu_pkg::*;;
   logic               valid;
   logic               ready;
   logic               action;
   logic [COLOR_W-1:0] blue_in;
   logic [COLOR_W-1:0] green_in;
   logic [COLOR_W-1:0] red_in;

   modport source (output valid, action, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, action, blue_in, green_in, red_in, output ready);
endinterface

// output pixel stream
interface ipu_rsp_if import ipu_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] blue_out;
   logic [COLOR_W-1:0] green_out;
   logic [COLOR_W-1:0] red_out;
   logic [PAD_W-1:0]   pad_bytes;
   logic               row_end;
   logic               last;

   modport source (output valid, blue_out, green_out, red_out, pad_bytes, row_end, last,
                   input ready);
   modport sink   (input valid, blue_out, green_out, red_out, pad_bytes, row_end, last,
                   output ready);
endinterface

// register write channel
interface ipu_csr_if import ipu_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/integer_pixel_upscaler_top.sv
// Nearest-neighbor integer upscaler built around a single line memory.
//
// Channels: req_chan takes one transaction per source pixel (action 0) or per
// replay of the next buffered pixel (action 1). rsp_chan delivers factor copies
// of that pixel, one per cycle while rsp_chan.ready is high; last marks the final
// copy of a transaction and row_end/pad_bytes mark the end of an output row.
// csr_chan writes input_width (index 0) and scale_factor (index 1); it is always
// ready and is meant to be used while the block is idle.
// A request passes the request stage, then the emitter, which holds the line
// memory read data, before its first copy is valid on rsp_chan.
// The emitter sends one copy per cycle while rsp_chan.ready is high; with factor
// 1 a request is taken every cycle while rsp_chan.ready is high. The next
// request is taken while the emitter still sends the copies of the last one.
// Requests that produce nothing (a pixel while rows are left to replay, a
// replay with none left) are taken and leave no trace.
// Reset clears the column and row counters and sets both registers to 1; the
// line memory is not cleared and needs no clearing pass.
// A stall on rsp_chan holds the current copy and, once the request stage is
// full, drops req_chan.ready.
module integer_pixel_upscaler_top import ipu_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
   input  logic        clock,
   input  logic        reset,
   ipu_req_if.sink     req_chan,
   ipu_rsp_if.source   rsp_chan,
   ipu_csr_if.sink     csr_chan
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W   = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;
   localparam int FACT_W  = $clog2(MAX_FACTOR + 1);
   localparam int ROWS_W  = $clog2(MAX_FACTOR);

   // configuration registers
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [FACTOR_REG_W-1:0] factor_ff;

   // sequencing state
   logic [COL_W-1:0]  write_column_ff, write_column_in;
   logic [COL_W-1:0]  replay_column_ff, replay_column_in;
   logic [ROWS_W-1:0] rows_left_ff, rows_left_in;

   // request stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_replay_ff;
   pixel_type         s1_pix_ff;
   logic              s1_end_ff;

   // emitter
   logic              em_valid_ff, em_valid_in;
   logic [FACT_W-1:0] em_left_ff, em_left_in;
   pixel_type         em_pix_ff, em_pix_in;
   logic              em_end_ff, em_end_in;

   // line memory
   pixel_type         line_mem [MAX_WIDTH];
   pixel_type         rd_data_ff;
   logic              mem_wr_en;
   logic              mem_rd_en;

   // derived configuration
   logic [CMP_W-1:0]  width_ext;
   logic [CMP_W-1:0]  eff_width;
   logic [COL_W-1:0]  last_col;
   logic [FACT_W-1:0] eff_factor;
   logic [3:0]        pad_prod;
   logic [PAD_W-1:0]  pad_value;

   // item decode
   logic              req_accept;
   logic              take_pixel;
   logic              take_replay;
   logic [COL_W-1:0]  wcol;
   logic [COL_W-1:0]  rcol;
   logic              wr_at_end;
   logic              rd_at_end;
   pixel_type         in_pix;

   // emitter handshake
   logic              em_final;
   logic              em_take;
   logic              em_free;
   logic              s1_move;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(1);
         factor_ff <= FACTOR_REG_W'(1);
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_INPUT_WIDTH:  width_ff  <= csr_chan.data[WIDTH_REG_W-1:0];
            CSR_SCALE_FACTOR: factor_ff <= csr_chan.data[FACTOR_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // effective width, factor and row padding
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      last_col = COL_W'(eff_width - CMP_W'(1));

      if (factor_ff == '0) begin
         eff_factor = FACT_W'(1);
      end else if (factor_ff > FACTOR_REG_W'(MAX_FACTOR)) begin
         eff_factor = FACT_W'(MAX_FACTOR);
      end else begin
         eff_factor = FACT_W'(factor_ff);
      end

      // output width mod 4 only needs the low two bits of each operand
      pad_prod  = {2'b00, eff_width[1:0]} * {2'b00, eff_factor[1:0]};
      pad_value = pad_prod[PAD_W-1:0];
   end

   // emitter and request stage handshake
   assign em_final   = (em_left_ff == FACT_W'(1));
   assign em_take    = em_valid_ff && rsp_chan.ready;
   assign em_free    = !em_valid_ff || (em_take && em_final);
   assign s1_move    = s1_valid_ff && em_free;
   assign req_chan.ready = !s1_valid_ff || em_free;
   assign req_accept = req_chan.valid && req_chan.ready;

   // item decode against current counters
   always_comb begin
      take_pixel  = req_accept && (action_type'(req_chan.action) == ACT_PIXEL)
                    && (rows_left_ff == '0);
      take_replay = req_accept && (action_type'(req_chan.action) == ACT_REPLAY)
                    && (rows_left_ff != '0);
      wcol        = (write_column_ff > last_col) ? last_col : write_column_ff;
      rcol        = (replay_column_ff > last_col) ? last_col : replay_column_ff;
      wr_at_end   = (wcol == last_col);
      rd_at_end   = (rcol == last_col);
      in_pix      = '{red: req_chan.red_in, green: req_chan.green_in,
                      blue: req_chan.blue_in};
      mem_wr_en   = take_pixel;
      mem_rd_en   = take_replay;
   end

   // column and row counters
   always_comb begin
      write_column_in  = write_column_ff;
      replay_column_in = replay_column_ff;
      rows_left_in     = rows_left_ff;
      if (take_pixel) begin
         if (wr_at_end) begin
            write_column_in  = '0;
            replay_column_in = '0;
            rows_left_in     = ROWS_W'(eff_factor - FACT_W'(1));
         end else begin
            write_column_in  = wcol + COL_W'(1);
         end
      end else if (take_replay) begin
         if (rd_at_end) begin
            replay_column_in = '0;
            rows_left_in     = rows_left_ff - ROWS_W'(1);
         end else begin
            replay_column_in = rcol + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_column_ff  <= '0;
         replay_column_ff <= '0;
         rows_left_ff     <= '0;
      end else begin
         write_column_ff  <= write_column_in;
         replay_column_ff <= replay_column_in;
         rows_left_ff     <= rows_left_in;
      end
   end

   // line memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         line_mem[wcol] <= in_pix;
      end
      if (mem_rd_en) begin
         rd_data_ff <= line_mem[rcol];
      end
   end

   // request stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take_pixel || take_replay) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel || take_replay) begin
         s1_replay_ff <= take_replay;
         s1_pix_ff    <= in_pix;
         s1_end_ff    <= take_pixel ? wr_at_end : rd_at_end;
      end
   end

   // emitter, one copy per cycle while rsp_chan.ready is high
   always_comb begin
      em_valid_in = em_valid_ff;
      em_left_in  = em_left_ff;
      em_pix_in   = em_pix_ff;
      em_end_in   = em_end_ff;
      if (s1_move) begin
         em_valid_in = 1'b1;
         em_left_in  = eff_factor;
         em_pix_in   = s1_replay_ff ? rd_data_ff : s1_pix_ff;
         em_end_in   = s1_end_ff;
      end else if (em_take) begin
         if (em_final) begin
            em_valid_in = 1'b0;
         end
         em_left_in = em_left_ff - FACT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_left_ff  <= '0;
      end else begin
         em_valid_ff <= em_valid_in;
         em_left_ff  <= em_left_in;
      end
   end

   always_ff @(posedge clock) begin
      em_pix_ff <= em_pix_in;
      em_end_ff <= em_end_in;
   end

   // result channel
   assign rsp_chan.valid     = em_valid_ff;
   assign rsp_chan.blue_out  = em_pix_ff.blue;
   assign rsp_chan.green_out = em_pix_ff.green;
   assign rsp_chan.red_out   = em_pix_ff.red;
   assign rsp_chan.last      = em_final;
   assign rsp_chan.row_end   = em_final && em_end_ff;
   assign rsp_chan.pad_bytes = (em_final && em_end_ff) ? pad_value : '0;

   // a busy emitter always has copies left to send
   a_em_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff |-> (em_left_ff != '0))
      else $error("emitter valid with no copies left");

   // while rows are replayed, the next source row starts at column zero
   a_write_col_parked: assert property (@(posedge clock) disable iff (reset)
      (rows_left_ff != '0) |-> (write_column_ff == '0))
      else $error("write column moved while rows remain to replay");

   // a full request stage that cannot move holds off new requests
   a_stage_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !em_free) |-> !req_chan.ready)
      else $error("request taken while request stage is blocked");

   // final copy taken with nothing queued leaves the emitter empty
   a_em_drains: assert property (@(posedge clock) disable iff (reset)
      (em_take && em_final && !s1_valid_ff) |=> !em_valid_ff)
      else $error("emitter did not drain after its final copy");

   // a pixel and a replay never touch the line memory in the same cycle
   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("line memory written and read by one request");

endmodule
